// ----- src/ppp_pkg.sv -----
// ----------------------------------------------------------------------------
// ppp_pkg
// Shared widths and codes for the perspective point projection core.
// ----------------------------------------------------------------------------
package ppp_pkg;

	localparam int DATA_W    = 32;              // Q format word
	localparam int PROD_W    = 2 * DATA_W;      // exact product / row accumulator
	localparam int DIG_W     = 8;               // multiplier digit
	localparam int NDIG      = DATA_W / DIG_W;  // digits per operand
	localparam int DIG_CNT_W = $clog2(NDIG);
	localparam int SIZE_W    = 15;              // display size register
	localparam int NUM_W     = DATA_W + 1 + SIZE_W + 1; // scaled numerator, signed
	localparam int NENT      = 12;
	localparam int IDX_W     = 4;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_HEIGHT = 2'd1;

	localparam logic MODE_LOAD    = 1'b0;
	localparam logic MODE_PROJECT = 1'b1;

	localparam logic [SIZE_W-1:0] WIDTH_RESET  = 15'd1920;
	localparam logic [SIZE_W-1:0] HEIGHT_RESET = 15'd1080;

	// first matrix entry of each row, in the order the rows are summed
	localparam logic [IDX_W-1:0] BASE_W = 4'd8;
	localparam logic [IDX_W-1:0] BASE_X = 4'd0;
	localparam logic [IDX_W-1:0] BASE_Y = 4'd4;
	localparam logic [IDX_W-1:0] M33_IDX = 4'd11;

	localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

endpackage

// ----- src/perspective_point_projection_core.sv -----
// ----------------------------------------------------------------------------
// perspective_point_projection_core
// World-to-screen projection with rows 0, 1 and 3 of a 4x4 view matrix.
// ----------------------------------------------------------------------------
// A load item writes one matrix entry; the core stays idle. A project item
// sums the W, X and Y rows in turn and is rejected after the W row when m33
// is zero or W is below threshold. Each row sum runs its three products
// through one digit-serial multiplier (four 8-bit digits plus start and
// finish). Each screen axis then scales by the display size and divides by
// W in a radix-2 divider. Items are handled one at a time; a finished result
// waits in the output register while the next item is accepted.
module perspective_point_projection_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      in_valid,
	output logic                                      in_ready,
	input  logic                                      mode,
	input  logic [ppp_pkg::IDX_W-1:0]                 entry_index,
	input  logic signed [ppp_pkg::DATA_W-1:0]         entry_value,
	input  logic signed [ppp_pkg::DATA_W-1:0]         point_x,
	input  logic signed [ppp_pkg::DATA_W-1:0]         point_y,
	input  logic signed [ppp_pkg::DATA_W-1:0]         point_z,
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic signed [ppp_pkg::DATA_W-1:0]         screen_x,
	output logic signed [ppp_pkg::DATA_W-1:0]         screen_y,
	output logic                                      result_valid,
	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  logic [ppp_pkg::CFG_IDX_W-1:0]             cfg_index,
	input  logic [ppp_pkg::SIZE_W-1:0]                cfg_data
);
	import ppp_pkg::*;

	localparam logic signed [DATA_W-1:0] W_THRESH =
		DATA_W'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_RINIT  = 4'd1;
	localparam logic [3:0] S_MSTART = 4'd2;
	localparam logic [3:0] S_MWAIT  = 4'd3;
	localparam logic [3:0] S_ROW    = 4'd4;
	localparam logic [3:0] S_SCALE  = 4'd5;
	localparam logic [3:0] S_DSTART = 4'd6;
	localparam logic [3:0] S_DWAIT  = 4'd7;
	localparam logic [3:0] S_DONE   = 4'd8;

	localparam logic [1:0] ROW_W = 2'd0;
	localparam logic [1:0] ROW_X = 2'd1;
	localparam logic [1:0] ROW_Y = 2'd2;

	logic [3:0]                state_q;
	logic [1:0]                row_q;
	logic [1:0]                col_q;
	logic                      axis_q;
	logic signed [DATA_W-1:0]  m_q [NENT];
	logic [SIZE_W-1:0]         width_q;
	logic [SIZE_W-1:0]         height_q;
	logic signed [DATA_W-1:0]  px_q, py_q, pz_q;
	logic signed [PROD_W-1:0]  acc_q;
	logic signed [DATA_W-1:0]  w_q, sx_q, sy_q, rx_q;
	logic signed [NUM_W-1:0]   num_q;
	logic                      out_valid_q;
	logic signed [DATA_W-1:0]  screen_x_q, screen_y_q;
	logic                      result_valid_q;
	logic signed [DATA_W-1:0]  res_x_q, res_y_q;
	logic                      res_ok_q;

	logic [IDX_W-1:0]          base;
	logic [IDX_W-1:0]          rd_idx;
	logic signed [DATA_W-1:0]  rd_val;
	logic signed [DATA_W-1:0]  pt_sel;
	logic signed [DATA_W-1:0]  row_sat;
	logic signed [DATA_W:0]    sum_sel;
	logic signed [SIZE_W:0]    size_sel;
	logic                      mac_start;
	logic                      mac_done;
	logic signed [PROD_W-1:0]  mac_prod;
	logic                      div_start;
	logic                      div_done;
	logic signed [DATA_W-1:0]  div_quo;
	logic                      in_acc;
	logic                      out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid & in_ready;
	assign cfg_ready = 1'b1;
	assign out_free  = ~out_valid_q | out_ready;

	always_comb begin
		unique case (row_q)
			ROW_W:   base = BASE_W;
			ROW_X:   base = BASE_X;
			default: base = BASE_Y;
		endcase
	end

	assign rd_idx = base + ((state_q == S_RINIT) ? IDX_W'(3) : IDX_W'(col_q));
	assign rd_val = m_q[rd_idx];

	always_comb begin
		unique case (col_q)
			2'd0:    pt_sel = px_q;
			2'd1:    pt_sel = py_q;
			default: pt_sel = pz_q;
		endcase
	end

	// clamp the row sum to a word
	always_comb begin
		if (acc_q > PROD_W'(SAT_MAX)) begin
			row_sat = SAT_MAX;
		end else if (acc_q < PROD_W'(SAT_MIN)) begin
			row_sat = SAT_MIN;
		end else begin
			row_sat = acc_q[DATA_W-1:0];
		end
	end

	assign sum_sel  = axis_q ? ((DATA_W+1)'(w_q) - (DATA_W+1)'(sy_q))
	                         : ((DATA_W+1)'(w_q) + (DATA_W+1)'(sx_q));
	assign size_sel = $signed({1'b0, axis_q ? height_q : width_q});

	assign mac_start = (state_q == S_MSTART);
	assign div_start = (state_q == S_DSTART);

	ppp_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mac_start),
		.mult_a (rd_val),
		.mult_b (pt_sel),
		.done   (mac_done),
		.prod   (mac_prod)
	);

	ppp_div #(.SHIFT(FRAC_BITS - 1)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (w_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	// matrix entries and display size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NENT; i++) begin
				m_q[i] <= '0;
			end
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else begin
			if (in_acc && mode == MODE_LOAD && entry_index < IDX_W'(NENT)) begin
				m_q[entry_index] <= entry_value;
			end
			if (cfg_valid && cfg_index == REG_DISPLAY_WIDTH) begin
				width_q <= cfg_data;
			end
			if (cfg_valid && cfg_index == REG_DISPLAY_HEIGHT) begin
				height_q <= cfg_data;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			row_q       <= ROW_W;
			col_q       <= '0;
			axis_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && mode == MODE_PROJECT) begin
						row_q   <= ROW_W;
						state_q <= S_RINIT;
					end
				end
				S_RINIT: begin
					col_q   <= '0;
					state_q <= S_MSTART;
				end
				S_MSTART: begin
					state_q <= S_MWAIT;
				end
				S_MWAIT: begin
					if (mac_done) begin
						if (col_q == 2'd2) begin
							state_q <= S_ROW;
						end else begin
							col_q   <= col_q + 1'b1;
							state_q <= S_MSTART;
						end
					end
				end
				S_ROW: begin
					priority case (row_q)
						ROW_W: begin
							if (m_q[M33_IDX] == '0 || row_sat < W_THRESH) begin
								state_q <= S_DONE;
							end else begin
								row_q   <= ROW_X;
								state_q <= S_RINIT;
							end
						end
						ROW_X: begin
							row_q   <= ROW_Y;
							state_q <= S_RINIT;
						end
						default: begin
							axis_q  <= 1'b0;
							state_q <= S_SCALE;
						end
					endcase
				end
				S_SCALE: begin
					state_q <= S_DSTART;
				end
				S_DSTART: begin
					state_q <= S_DWAIT;
				end
				S_DWAIT: begin
					if (div_done) begin
						if (axis_q) begin
							state_q <= S_DONE;
						end else begin
							axis_q  <= 1'b1;
							state_q <= S_SCALE;
						end
					end
				end
				S_DONE: begin
					// hold until the output register is free
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			px_q <= point_x;
			py_q <= point_y;
			pz_q <= point_z;
		end
		if (state_q == S_RINIT) begin
			acc_q <= PROD_W'(rd_val);
		end else if (state_q == S_MWAIT && mac_done) begin
			acc_q <= acc_q + mac_prod;
		end
		if (state_q == S_ROW) begin
			unique case (row_q)
				ROW_W: begin
					w_q      <= row_sat;
					res_ok_q <= 1'b0;
					res_x_q  <= '0;
					res_y_q  <= '0;
				end
				ROW_X:   sx_q <= row_sat;
				default: sy_q <= row_sat;
			endcase
		end
		if (state_q == S_SCALE) begin
			num_q <= sum_sel * size_sel;
		end
		if (state_q == S_DWAIT && div_done) begin
			if (axis_q) begin
				res_x_q  <= rx_q;
				res_y_q  <= div_quo;
				res_ok_q <= 1'b1;
			end else begin
				rx_q <= div_quo;
			end
		end
		if (state_q == S_DONE && out_free) begin
			screen_x_q     <= res_x_q;
			screen_y_q     <= res_y_q;
			result_valid_q <= res_ok_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign screen_x     = screen_x_q;
	assign screen_y     = screen_y_q;
	assign result_valid = result_valid_q;

endmodule

// ----- src/ppp_mac.sv -----
// ----------------------------------------------------------------------------
// ppp_mac
// Digit-serial signed multiplier: one 8-bit digit of the point per cycle.
// ----------------------------------------------------------------------------
module ppp_mac #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [ppp_pkg::DATA_W-1:0]   mult_a,
	input  logic signed [ppp_pkg::DATA_W-1:0]   mult_b,
	output logic                                done,
	output logic signed [ppp_pkg::PROD_W-1:0]   prod
);
	import ppp_pkg::*;

	logic signed [DATA_W-1:0]      a_q;
	logic [DATA_W-1:0]             b_q;
	logic signed [PROD_W-1:0]      acc_q;
	logic [DIG_CNT_W-1:0]          dig_q;
	logic                          busy_q;
	logic                          done_q;
	logic                          last;
	logic signed [DIG_W:0]         digit;
	logic signed [DATA_W+DIG_W:0]  part;
	logic signed [PROD_W-1:0]      part_ext;

	assign last     = (dig_q == DIG_CNT_W'(NDIG - 1));
	// top digit carries the sign, the others are unsigned
	assign digit    = {last & b_q[DIG_W-1], b_q[DIG_W-1:0]};
	assign part     = a_q * digit;
	assign part_ext = PROD_W'(part);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			dig_q  <= '0;
		end else begin
			done_q <= busy_q & last;
			if (start) begin
				busy_q <= 1'b1;
				dig_q  <= '0;
			end else if (busy_q) begin
				dig_q <= dig_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= mult_a;
			b_q   <= mult_b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + (part_ext <<< (int'(dig_q) * DIG_W));
			b_q   <= b_q >> DIG_W;
		end
	end

	assign done = done_q;
	// floor shift of the exact product
	assign prod = acc_q >>> FRAC_BITS;

endmodule

// ----- src/ppp_div.sv -----
// ----------------------------------------------------------------------------
// ppp_div
// Restoring divider, one quotient bit per cycle: num * 2^SHIFT / den,
// truncated toward zero and saturated to a signed word.
// ----------------------------------------------------------------------------
module ppp_div #(
	parameter int SHIFT = 15
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [ppp_pkg::NUM_W-1:0]   num,
	input  logic [ppp_pkg::DATA_W-1:0]         den,
	output logic                               done,
	output logic signed [ppp_pkg::DATA_W-1:0]  quo
);
	import ppp_pkg::*;

	localparam int AW    = NUM_W - 1;
	localparam int NW    = AW + SHIFT;
	localparam int HW    = NW - DATA_W;
	localparam int CNT_W = $clog2(DATA_W + 1);

	logic [NUM_W-1:0]    mag;
	logic [NW-1:0]       nshift;
	logic [HW-1:0]       hi;
	logic                ovf;
	logic [DATA_W-1:0]   rem_q;
	logic [DATA_W-1:0]   sh_q;
	logic [DATA_W-1:0]   den_q;
	logic                neg_q;
	logic                ovf_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [DATA_W:0]     cur;
	logic [DATA_W:0]     diff;
	logic                ge;

	assign mag    = num[NUM_W-1] ? (~num + 1'b1) : num;
	assign nshift = {mag[AW-1:0], {SHIFT{1'b0}}};
	assign hi     = nshift[NW-1:DATA_W];
	// quotient would need more than a word: saturate
	assign ovf    = (NW'(hi) >= NW'(den));

	assign cur  = {rem_q, sh_q[DATA_W-1]};
	assign diff = cur - {1'b0, den_q};
	assign ge   = (cur >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DATA_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DATA_W'(hi);
			sh_q  <= nshift[DATA_W-1:0];
			den_q <= den;
			neg_q <= num[NUM_W-1];
			ovf_q <= ovf;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DATA_W-1:0] : cur[DATA_W-1:0];
			sh_q  <= {sh_q[DATA_W-2:0], ge};
		end
	end

	always_comb begin
		if (ovf_q) begin
			quo = neg_q ? SAT_MIN : SAT_MAX;
		end else if (neg_q) begin
			quo = (sh_q[DATA_W-1] && (|sh_q[DATA_W-2:0])) ? SAT_MIN : -$signed(sh_q);
		end else begin
			quo = sh_q[DATA_W-1] ? SAT_MAX : $signed(sh_q);
		end
	end

	assign done = done_q;

endmodule

// ----- tb/perspective_point_projection_core_tb.sv -----
// ----------------------------------------------------------------------------
// perspective_point_projection_core_tb
// Self-checking bench: matrix loads, point projections, display size writes.
// Each project item is predicted in Q16.16 and compared with the result item.
// ----------------------------------------------------------------------------
module perspective_point_projection_core_tb;
	import ppp_pkg::*;

	localparam int FRAC = 16;
	localparam longint W_MIN = ((64'sd1 <<< FRAC) + 50) / 100;
	localparam longint LIMIT = 3000000;

	typedef struct packed {
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic               ok;
	} screen_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic mode = MODE_LOAD;
	logic [IDX_W-1:0] entry_index = '0;
	logic signed [31:0] entry_value = '0;
	logic signed [31:0] point_x = '0;
	logic signed [31:0] point_y = '0;
	logic signed [31:0] point_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] screen_x;
	logic signed [31:0] screen_y;
	logic result_valid;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [SIZE_W-1:0] cfg_data = '0;

	perspective_point_projection_core i_dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	logic signed [31:0] mat [NENT];
	longint disp_w, disp_h;
	screen_t pending_screens [$];
	int errors = 0;
	longint cycles = 0;
	bit idle_en = 1'b1;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint row_dot(int b, longint px, longint py, longint pz);
		longint acc;
		acc = mat[b+3];
		acc += (longint'(mat[b]) * px) >>> FRAC;
		acc += (longint'(mat[b+1]) * py) >>> FRAC;
		acc += (longint'(mat[b+2]) * pz) >>> FRAC;
		return sat32(acc);
	endfunction

	// num * 2^s / den toward zero, quotient capped at 2^33 as it is built
	function automatic longint scale_div(longint num, longint den, int s);
		logic [63:0] a, q, r, cap;
		bit neg;
		cap = 64'd1 << 33;
		neg = num < 0;
		a = neg ? -num : num;
		q = a / den;
		r = a % den;
		if (q > cap) q = cap;
		for (int i = 0; i < s; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q[0] = 1'b1;
			end
			if (q > cap) q = cap;
		end
		return sat32(neg ? -longint'(q) : longint'(q));
	endfunction

	function automatic screen_t project_point(longint px, longint py, longint pz);
		screen_t s;
		longint w, x, y;
		s = '0;
		if (mat[M33_IDX] == 0) return s;
		w = row_dot(BASE_W, px, py, pz);
		if (w < W_MIN) return s;
		x = row_dot(BASE_X, px, py, pz);
		y = row_dot(BASE_Y, px, py, pz);
		s.sx = 32'(scale_div(disp_w * (w + x), w, FRAC - 1));
		s.sy = 32'(scale_div(disp_h * (w - y), w, FRAC - 1));
		s.ok = 1'b1;
		return s;
	endfunction

	task automatic idle_burst();
		if (idle_en && $urandom_range(3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(16, 1)) @(posedge clk);
		end
	endtask

	// valid stays up into the next item unless the sender idles or drains
	task automatic send_item(logic m, logic [3:0] idx, logic [31:0] val,
			logic [31:0] x, logic [31:0] y, logic [31:0] z);
		idle_burst();
		in_valid <= 1'b1;
		mode <= m;
		entry_index <= idx;
		entry_value <= val;
		point_x <= x;
		point_y <= y;
		point_z <= z;
		do @(posedge clk); while (!in_ready);
		if (m == MODE_LOAD) begin
			if (idx < NENT) mat[idx] = val;
		end else
			pending_screens.push_back(project_point(signed'(x), signed'(y), signed'(z)));
	endtask

	task automatic load_entry(int idx, logic [31:0] val);
		send_item(MODE_LOAD, IDX_W'(idx), val, $urandom, $urandom, $urandom);
	endtask

	task automatic project(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		send_item(MODE_PROJECT, IDX_W'($urandom), $urandom, x, y, z);
	endtask

	// hold until drained plus room for a rejected or load item in flight
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_screens.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_DISPLAY_WIDTH) disp_w = val;
		else if (idx == REG_DISPLAY_HEIGHT) disp_h = val;
	endtask

	always @(posedge clk) begin
		screen_t want;
		if (out_valid && out_ready) begin
			if (pending_screens.size() == 0) begin
				$error("result item with nothing expected");
				errors++;
			end else begin
				want = pending_screens.pop_front();
				if (screen_x !== want.sx) begin
					$error("screen_x exp %0d got %0d", want.sx, screen_x);
					errors++;
				end
				if (screen_y !== want.sy) begin
					$error("screen_y exp %0d got %0d", want.sy, screen_y);
					errors++;
				end
				if (result_valid !== want.ok) begin
					$error("result_valid exp %0d got %0d", want.ok, result_valid);
					errors++;
				end
			end
		end
	end

	// stall the output at random while idling is enabled
	always begin
		@(posedge clk);
		if (idle_en && $urandom_range(5) == 0) begin
			out_ready <= 1'b0;
			repeat ($urandom_range(16, 1)) @(posedge clk);
		end
		out_ready <= 1'b1;
	end

	task automatic load_camera();
		for (int i = 0; i < NENT; i++)
			load_entry(i, (i % 4 == i / 4 || i == 11) ? 32'h0001_0000
				: $urandom_range(65536 * 2) - 65536);
	endtask

	task automatic test_directed();
		// zero m33 rejects
		project(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
		load_camera();
		project(0, 0, 0);
		project(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
		project(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		load_entry(M33_IDX, 32'd655); // weight exactly at threshold
		load_entry(8, 0);
		load_entry(9, 0);
		load_entry(10, 0);
		project(1, 2, 3);
		load_entry(M33_IDX, 32'd656);
		project(1, 2, 3);
		load_entry(M33_IDX, 32'hffff_0000); // negative weight
		project(5, 5, 5);
		load_entry(12, 32'hdead_beef); // ignored index
		load_entry(15, 32'h1234_5678);
		load_entry(M33_IDX, 32'h7fff_ffff);
		load_entry(0, 32'h8000_0000);
		load_entry(4, 32'h7fff_ffff);
		project(32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff);
		project(32'hffff_ffff, 0, 0);
	endtask

	task automatic test_random(int n);
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(9))
				0: load_entry($urandom_range(15), $urandom);
				1, 2: load_entry($urandom_range(11),
					$urandom_range(1) ? $urandom
						: $urandom_range(32'h4_0000) - 32'h2_0000);
				3: project($urandom, $urandom, $urandom);
				4: load_entry(M33_IDX,
					$urandom_range(3) == 0 ? 0 : $urandom_range(32'h3_0000));
				default: project($urandom_range(32'h10_0000) - 32'h8_0000,
					$urandom_range(32'h10_0000) - 32'h8_0000,
					$urandom_range(32'h10_0000) - 32'h8_0000);
			endcase
		end
	endtask

	task automatic test_sizes();
		write_reg(REG_DISPLAY_WIDTH, 15'd1);
		write_reg(REG_DISPLAY_HEIGHT, 15'd16384);
		test_random(120);
		write_reg(REG_DISPLAY_WIDTH, 15'h7fff);
		write_reg(REG_DISPLAY_HEIGHT, 15'd0);
		write_reg(2'd3, 15'h1234); // ignored register
		load_camera();
		test_random(120);
		write_reg(REG_DISPLAY_WIDTH, 15'd0);
		write_reg(REG_DISPLAY_HEIGHT, 15'd1);
		test_random(100);
		write_reg(REG_DISPLAY_WIDTH, SIZE_W'($urandom_range(16384, 1)));
		write_reg(REG_DISPLAY_HEIGHT, SIZE_W'($urandom_range(16384, 1)));
	endtask

	initial begin
		for (int i = 0; i < NENT; i++) mat[i] = '0;
		disp_w = WIDTH_RESET;
		disp_h = HEIGHT_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(300);
		test_sizes();
		load_camera();
		test_random(250);
		idle_en = 1'b0;
		test_random(150);
		drain();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- sim.f -----
src/ppp_pkg.sv
src/ppp_mac.sv
src/ppp_div.sv
src/perspective_point_projection_core.sv
tb/perspective_point_projection_core_tb.sv
